// ===== hw/rtl/tpdc_pkg.sv =====
// ----------------------------------------------------------------------------
// Tilt PID duty controller package
// Widths, fixed-point constants, register indexes, sequencer states and the
// arctangent table shared by the controller and its CORDIC unit.
// ----------------------------------------------------------------------------
package tpdc_pkg;

  // CORDIC iteration count (the arctangent table holds entries for indexes 0 to 22)
  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_IW    = $clog2(CORDIC_STEPS);
  localparam int ATAN_IDX_W   = 5;
  localparam int ATAN_W       = 22;

  // Field and datapath widths
  localparam int ACCEL_W     = 19;   // accelerometer sample, Q16 g
  localparam int GYRO_W      = 25;   // gyro rate, Q16 deg/s
  localparam int CORDIC_W    = 34;   // CORDIC x/y after pre-scale and growth
  localparam int PRESCALE_SH = 12;   // CORDIC input pre-scale
  localparam int ACC_ANG_W   = 27;   // accel angle, Q16 degrees
  localparam int ANGLE_W     = 25;   // filtered angle, Q16 degrees
  localparam int SUM_W       = 27;   // angle partial sums
  localparam int ERR_W       = 26;   // setpoint error
  localparam int INTEG_W     = 32;   // error accumulator
  localparam int MUL_A_W     = 33;
  localparam int MUL_B_W     = 25;
  localparam int PROD_W      = MUL_A_W + MUL_B_W;
  localparam int FRAC_SH     = 16;   // Q16 product renormalisation
  localparam int PROD_SH_W   = 27;   // short Q16 products after the shift
  localparam int ACC_SH_W    = PROD_W - FRAC_SH;
  localparam int DUTY_W      = 40;   // duty, Q24
  localparam int DIFF_W      = DUTY_W + 1;
  localparam int SMOOTH_SH   = 4;    // 1/16 smoothing
  localparam int DCL_W       = 25;   // duty clamped to 0..1, Q24
  localparam int PWM_W       = 16;
  localparam int PWM_SH      = 24;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;
  localparam int TARGET_W   = 24;
  localparam int GAIN_W     = 24;
  localparam int LIMIT_W    = 31;
  localparam int FS_W       = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_ANGLE    = 3'd0,
    CFG_GAIN_PROP       = 3'd1,
    CFG_GAIN_INTEG      = 3'd2,
    CFG_GAIN_DERIV      = 3'd3,
    CFG_INTEGRAL_LIMIT  = 3'd4,
    CFG_DUTY_FULL_SCALE = 3'd5
  } cfg_reg_t;

  // Register reset values
  localparam logic [TARGET_W-1:0] RST_TARGET = 24'd655360;
  localparam logic [GAIN_W-1:0]   RST_KP     = 24'd268435;
  localparam logic [GAIN_W-1:0]   RST_KI     = 24'd839;
  localparam logic [GAIN_W-1:0]   RST_KD     = 24'd167772;
  localparam logic [LIMIT_W-1:0]  RST_LIMIT  = 31'd1179648000;
  localparam logic [FS_W-1:0]     RST_FS     = 16'd2000;

  // Filter weights (Q16) and saturation bounds
  localparam logic signed [MUL_B_W-1:0]   W_GYRO   = -25'sd65;
  localparam logic signed [MUL_B_W-1:0]   W_DECAY  = 25'sd65470;
  localparam logic signed [MUL_B_W-1:0]   W_ACCEL  = 25'sd65;
  localparam logic signed [ACC_ANG_W-1:0] ANG_180  = 27'sd11796480;
  localparam logic signed [SUM_W:0]       ANG_MAX  = 28'sd16777215;
  localparam logic signed [SUM_W:0]       ANG_MIN  = -28'sd16777216;
  localparam logic signed [ACC_SH_W-1:0]  RAW_MAX  = 42'sd549755813887;
  localparam logic signed [ACC_SH_W-1:0]  RAW_MIN  = -42'sd549755813888;
  localparam logic signed [DUTY_W-1:0]    DUTY_ONE = 40'sd16777216;

  // Controller sequencer
  typedef enum logic [3:0] {
    S_IDLE,
    S_CORDIC,
    S_SUM,
    S_MUL_DECAY,
    S_MUL_ACCEL,
    S_ANGLE,
    S_ERR,
    S_INTEG,
    S_MUL_I,
    S_MUL_D,
    S_RAW,
    S_CLAMP_RAW,
    S_SMOOTH,
    S_CLAMP_D,
    S_MUL_PWM,
    S_RESULT
  } state_t;

  // Arctangent of 2^-i in Q16 degrees
  function automatic logic [ATAN_W-1:0] atan_deg(input logic [ATAN_IDX_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    unique case (idx)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234379;
      5'd5:    v = 22'd117304;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      5'd17:   v = 22'd29;
      5'd18:   v = 22'd14;
      5'd19:   v = 22'd7;
      5'd20:   v = 22'd4;
      5'd21:   v = 22'd2;
      5'd22:   v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/tpdc_cordic.sv =====
// ----------------------------------------------------------------------------
// Tilt PID CORDIC angle unit
// Vectoring CORDIC that finds atan2(z, y) in Q16 degrees, one micro-rotation
// per cycle through a single add/subtract/shift stage.
// ----------------------------------------------------------------------------
module tpdc_cordic (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      start,
  input  logic signed [tpdc_pkg::ACCEL_W-1:0]       accel_y,
  input  logic signed [tpdc_pkg::ACCEL_W-1:0]       accel_z,
  output logic                                      done,
  output logic signed [tpdc_pkg::ACC_ANG_W-1:0]     angle
);

  logic signed [tpdc_pkg::CORDIC_W-1:0]  x_r, x_nxt, y_r, y_nxt;
  logic signed [tpdc_pkg::CORDIC_W-1:0]  x_sh, y_sh, x_init, y_init;
  logic signed [tpdc_pkg::ACC_ANG_W-1:0] a_r, a_nxt, atan_s;
  logic [tpdc_pkg::CORDIC_IW-1:0]        step_r, step_nxt;
  logic                                  busy_r, busy_nxt, done_r, done_nxt;
  logic                                  zero_r, zero_nxt;
  logic                                  last_step;

  // Pre-scaled start vector
  assign x_init = tpdc_pkg::CORDIC_W'($signed({accel_y, {tpdc_pkg::PRESCALE_SH{1'b0}}}));
  assign y_init = tpdc_pkg::CORDIC_W'($signed({accel_z, {tpdc_pkg::PRESCALE_SH{1'b0}}}));

  // Shared shift and table lookup for the current micro-rotation
  assign x_sh      = x_r >>> step_r;
  assign y_sh      = y_r >>> step_r;
  assign atan_s    = tpdc_pkg::ACC_ANG_W'($signed({1'b0,
                       tpdc_pkg::atan_deg(tpdc_pkg::ATAN_IDX_W'(step_r))}));
  assign last_step = (step_r == tpdc_pkg::CORDIC_IW'(tpdc_pkg::CORDIC_STEPS - 1));

  // Load on start, otherwise rotate towards the x axis
  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    a_nxt    = a_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    zero_nxt = zero_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      zero_nxt = (accel_y == '0) && (accel_z == '0);
      if (accel_y < 0) begin
        x_nxt = -x_init;
        y_nxt = -y_init;
        a_nxt = (accel_z >= 0) ? tpdc_pkg::ANG_180 : -tpdc_pkg::ANG_180;
      end else begin
        x_nxt = x_init;
        y_nxt = y_init;
        a_nxt = '0;
      end
    end else if (busy_r) begin
      if (y_r > 0) begin
        x_nxt = x_r + y_sh;
        y_nxt = y_r - x_sh;
        a_nxt = a_r + atan_s;
      end else begin
        x_nxt = x_r - y_sh;
        y_nxt = y_r + x_sh;
        a_nxt = a_r - atan_s;
      end
      step_nxt = step_r + 1'b1;
      if (last_step) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  // Rotation registers
  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    a_r    <= a_nxt;
    zero_r <= zero_nxt;
  end

  // A zero vector reads as zero degrees
  assign done  = done_r;
  assign angle = zero_r ? '0 : a_r;

endmodule

// ===== hw/rtl/tilt_pid_duty_controller.sv =====
// ----------------------------------------------------------------------------
// Tilt PID duty controller
// Complementary-filter tilt estimate followed by a PI controller with rate
// feedback, duty smoothing and scaling to a PWM level.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  in       input      in_valid / in_stall   accel_y, accel_z, gyro_x
//  out      output     out_valid / out_stall pwm_level, filtered_angle
//  cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
//  The time from one sample's acceptance to the next is set mostly by the
//  CORDIC loop and otherwise by the sequencer steps on the shared
//  33 x 25 multiplier, one product per sequencer step.
//  in_stall is high from acceptance until the result is registered.
//  A stalled result is held in the output register; the sequencer waits at
//  its last step only if a new result is ready before the old one is taken.
//  Reset (rst_n low, synchronous) restores the register defaults and clears
//  the angle estimate, error integral and smoothed duty.
// ----------------------------------------------------------------------------
module tilt_pid_duty_controller (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // input samples
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [tpdc_pkg::ACCEL_W-1:0]    in_accel_y,
  input  logic signed [tpdc_pkg::ACCEL_W-1:0]    in_accel_z,
  input  logic signed [tpdc_pkg::GYRO_W-1:0]     in_gyro_x,
  // results
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [tpdc_pkg::PWM_W-1:0]             out_pwm_level,
  output logic signed [tpdc_pkg::ANGLE_W-1:0]    out_filtered_angle,
  // configuration writes
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [tpdc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [tpdc_pkg::CFG_DATA_W-1:0]        cfg_data
);

  tpdc_pkg::state_t state_r, state_nxt;

  // Configuration registers
  logic [tpdc_pkg::TARGET_W-1:0] target_r;
  logic [tpdc_pkg::GAIN_W-1:0]   kp_r, ki_r, kd_r;
  logic [tpdc_pkg::LIMIT_W-1:0]  lim_r;
  logic [tpdc_pkg::FS_W-1:0]     fs_r;

  // Loop state
  logic signed [tpdc_pkg::ANGLE_W-1:0] ang_r, ang_nxt;
  logic signed [tpdc_pkg::INTEG_W-1:0] integ_r, integ_nxt;
  logic signed [tpdc_pkg::DUTY_W-1:0]  sd_r, sd_nxt;

  // Working registers
  logic signed [tpdc_pkg::GYRO_W-1:0]  gx_r, gx_nxt;
  logic signed [tpdc_pkg::SUM_W-1:0]   tmp_r, tmp_nxt;
  logic signed [tpdc_pkg::ERR_W-1:0]   err_r, err_nxt;
  logic signed [tpdc_pkg::PROD_W-1:0]  acc_r, acc_nxt;
  logic signed [tpdc_pkg::DIFF_W-1:0]  diff_r, diff_nxt;
  logic [tpdc_pkg::DCL_W-1:0]          dcl_r, dcl_nxt;
  logic signed [tpdc_pkg::PROD_W-1:0]  prod_r;
  logic signed [tpdc_pkg::MUL_A_W-1:0] mul_a;
  logic signed [tpdc_pkg::MUL_B_W-1:0] mul_b;

  // Output register
  logic                                out_valid_r, out_valid_nxt;
  logic [tpdc_pkg::PWM_W-1:0]          pwm_r;
  logic signed [tpdc_pkg::ANGLE_W-1:0] out_ang_r;
  logic                                out_load;

  // CORDIC unit
  logic                                   cor_start, cor_done;
  logic signed [tpdc_pkg::ACC_ANG_W-1:0]  cor_angle;

  // Arithmetic views of the registered values
  logic signed [tpdc_pkg::PROD_SH_W-1:0] prod_sh;
  logic signed [tpdc_pkg::SUM_W:0]       ang_sum;
  logic signed [tpdc_pkg::INTEG_W:0]     integ_sum, lim_pos;
  logic signed [tpdc_pkg::ACC_SH_W-1:0]  acc_sh;
  logic signed [tpdc_pkg::DUTY_W-1:0]    raw_sat;
  logic signed [tpdc_pkg::ACC_SH_W-1:0]  sd_sum;

  tpdc_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cor_start),
    .accel_y (in_accel_y),
    .accel_z (in_accel_z),
    .done    (cor_done),
    .angle   (cor_angle)
  );

  // Configuration writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= tpdc_pkg::RST_TARGET;
      kp_r     <= tpdc_pkg::RST_KP;
      ki_r     <= tpdc_pkg::RST_KI;
      kd_r     <= tpdc_pkg::RST_KD;
      lim_r    <= tpdc_pkg::RST_LIMIT;
      fs_r     <= tpdc_pkg::RST_FS;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tpdc_pkg::CFG_TARGET_ANGLE:    target_r <= cfg_data[tpdc_pkg::TARGET_W-1:0];
        tpdc_pkg::CFG_GAIN_PROP:       kp_r     <= cfg_data[tpdc_pkg::GAIN_W-1:0];
        tpdc_pkg::CFG_GAIN_INTEG:      ki_r     <= cfg_data[tpdc_pkg::GAIN_W-1:0];
        tpdc_pkg::CFG_GAIN_DERIV:      kd_r     <= cfg_data[tpdc_pkg::GAIN_W-1:0];
        tpdc_pkg::CFG_INTEGRAL_LIMIT:  lim_r    <= cfg_data[tpdc_pkg::LIMIT_W-1:0];
        tpdc_pkg::CFG_DUTY_FULL_SCALE: fs_r     <= cfg_data[tpdc_pkg::FS_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tpdc_pkg::S_IDLE:      if (in_valid) state_nxt = tpdc_pkg::S_CORDIC;
      tpdc_pkg::S_CORDIC:    if (cor_done) state_nxt = tpdc_pkg::S_SUM;
      tpdc_pkg::S_SUM:       state_nxt = tpdc_pkg::S_MUL_DECAY;
      tpdc_pkg::S_MUL_DECAY: state_nxt = tpdc_pkg::S_MUL_ACCEL;
      tpdc_pkg::S_MUL_ACCEL: state_nxt = tpdc_pkg::S_ANGLE;
      tpdc_pkg::S_ANGLE:     state_nxt = tpdc_pkg::S_ERR;
      tpdc_pkg::S_ERR:       state_nxt = tpdc_pkg::S_INTEG;
      tpdc_pkg::S_INTEG:     state_nxt = tpdc_pkg::S_MUL_I;
      tpdc_pkg::S_MUL_I:     state_nxt = tpdc_pkg::S_MUL_D;
      tpdc_pkg::S_MUL_D:     state_nxt = tpdc_pkg::S_RAW;
      tpdc_pkg::S_RAW:       state_nxt = tpdc_pkg::S_CLAMP_RAW;
      tpdc_pkg::S_CLAMP_RAW: state_nxt = tpdc_pkg::S_SMOOTH;
      tpdc_pkg::S_SMOOTH:    state_nxt = tpdc_pkg::S_CLAMP_D;
      tpdc_pkg::S_CLAMP_D:   state_nxt = tpdc_pkg::S_MUL_PWM;
      tpdc_pkg::S_MUL_PWM:   state_nxt = tpdc_pkg::S_RESULT;
      tpdc_pkg::S_RESULT:    if (!out_valid_r || !out_stall) state_nxt = tpdc_pkg::S_IDLE;
      default:               state_nxt = tpdc_pkg::S_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    in_stall  = (state_r != tpdc_pkg::S_IDLE);
    cor_start = (state_r == tpdc_pkg::S_IDLE) && in_valid;
    out_load  = (state_r == tpdc_pkg::S_RESULT) && (!out_valid_r || !out_stall);
  end

  // Renormalised products and partial sums
  assign prod_sh   = prod_r[tpdc_pkg::FRAC_SH+tpdc_pkg::PROD_SH_W-1:tpdc_pkg::FRAC_SH];
  assign ang_sum   = (tpdc_pkg::SUM_W+1)'(tmp_r) + (tpdc_pkg::SUM_W+1)'(prod_sh);
  assign integ_sum = (tpdc_pkg::INTEG_W+1)'(integ_r) + (tpdc_pkg::INTEG_W+1)'(err_r);
  assign lim_pos   = $signed({2'b00, lim_r});
  assign acc_sh    = acc_r[tpdc_pkg::PROD_W-1:tpdc_pkg::FRAC_SH];
  assign sd_sum    = tpdc_pkg::ACC_SH_W'(sd_r)
                   + tpdc_pkg::ACC_SH_W'($signed(diff_r[tpdc_pkg::DIFF_W-1:tpdc_pkg::SMOOTH_SH]));

  // Saturate the summed gain products to the duty range
  always_comb begin
    if (acc_sh > tpdc_pkg::RAW_MAX) begin
      raw_sat = tpdc_pkg::DUTY_W'(tpdc_pkg::RAW_MAX);
    end else if (acc_sh < tpdc_pkg::RAW_MIN) begin
      raw_sat = tpdc_pkg::DUTY_W'(tpdc_pkg::RAW_MIN);
    end else begin
      raw_sat = acc_sh[tpdc_pkg::DUTY_W-1:0];
    end
  end

  // Shared multiplier operands and register updates per step
  always_comb begin
    mul_a     = tpdc_pkg::MUL_A_W'(gx_r);
    mul_b     = tpdc_pkg::W_GYRO;
    gx_nxt    = gx_r;
    tmp_nxt   = tmp_r;
    err_nxt   = err_r;
    acc_nxt   = acc_r;
    diff_nxt  = diff_r;
    dcl_nxt   = dcl_r;
    ang_nxt   = ang_r;
    integ_nxt = integ_r;
    sd_nxt    = sd_r;
    unique case (state_r)
      tpdc_pkg::S_IDLE: begin
        if (in_valid) gx_nxt = in_gyro_x;
      end
      // gyro delta is multiplied while the CORDIC runs
      tpdc_pkg::S_CORDIC: ;
      tpdc_pkg::S_SUM: begin
        tmp_nxt = tpdc_pkg::SUM_W'(ang_r) + prod_sh;
      end
      tpdc_pkg::S_MUL_DECAY: begin
        mul_a = tpdc_pkg::MUL_A_W'(tmp_r);
        mul_b = tpdc_pkg::W_DECAY;
      end
      tpdc_pkg::S_MUL_ACCEL: begin
        mul_a   = tpdc_pkg::MUL_A_W'(cor_angle);
        mul_b   = tpdc_pkg::W_ACCEL;
        tmp_nxt = prod_sh;
      end
      tpdc_pkg::S_ANGLE: begin
        if (ang_sum > tpdc_pkg::ANG_MAX) begin
          ang_nxt = tpdc_pkg::ANGLE_W'(tpdc_pkg::ANG_MAX);
        end else if (ang_sum < tpdc_pkg::ANG_MIN) begin
          ang_nxt = tpdc_pkg::ANGLE_W'(tpdc_pkg::ANG_MIN);
        end else begin
          ang_nxt = ang_sum[tpdc_pkg::ANGLE_W-1:0];
        end
      end
      tpdc_pkg::S_ERR: begin
        err_nxt = $signed({2'b00, target_r}) - tpdc_pkg::ERR_W'(ang_r);
      end
      tpdc_pkg::S_INTEG: begin
        mul_a = tpdc_pkg::MUL_A_W'(err_r);
        mul_b = $signed({1'b0, kp_r});
        if (integ_sum > lim_pos) begin
          integ_nxt = tpdc_pkg::INTEG_W'(lim_pos);
        end else if (integ_sum < -lim_pos) begin
          integ_nxt = tpdc_pkg::INTEG_W'(-lim_pos);
        end else begin
          integ_nxt = integ_sum[tpdc_pkg::INTEG_W-1:0];
        end
      end
      tpdc_pkg::S_MUL_I: begin
        mul_a   = tpdc_pkg::MUL_A_W'(integ_r);
        mul_b   = $signed({1'b0, ki_r});
        acc_nxt = prod_r;
      end
      tpdc_pkg::S_MUL_D: begin
        mul_a   = tpdc_pkg::MUL_A_W'(gx_r);
        mul_b   = $signed({1'b0, kd_r});
        acc_nxt = acc_r + prod_r;
      end
      tpdc_pkg::S_RAW: begin
        acc_nxt = acc_r + prod_r;
      end
      tpdc_pkg::S_CLAMP_RAW: begin
        diff_nxt = tpdc_pkg::DIFF_W'(raw_sat) - tpdc_pkg::DIFF_W'(sd_r);
      end
      tpdc_pkg::S_SMOOTH: begin
        if (sd_sum > tpdc_pkg::RAW_MAX) begin
          sd_nxt = tpdc_pkg::DUTY_W'(tpdc_pkg::RAW_MAX);
        end else if (sd_sum < tpdc_pkg::RAW_MIN) begin
          sd_nxt = tpdc_pkg::DUTY_W'(tpdc_pkg::RAW_MIN);
        end else begin
          sd_nxt = sd_sum[tpdc_pkg::DUTY_W-1:0];
        end
      end
      tpdc_pkg::S_CLAMP_D: begin
        if (sd_r < 0) begin
          dcl_nxt = '0;
        end else if (sd_r > tpdc_pkg::DUTY_ONE) begin
          dcl_nxt = tpdc_pkg::DCL_W'(tpdc_pkg::DUTY_ONE);
        end else begin
          dcl_nxt = sd_r[tpdc_pkg::DCL_W-1:0];
        end
      end
      // keep the scaling product steady while the result waits
      tpdc_pkg::S_MUL_PWM, tpdc_pkg::S_RESULT: begin
        mul_a = $signed({{(tpdc_pkg::MUL_A_W-tpdc_pkg::DCL_W){1'b0}}, dcl_r});
        mul_b = $signed({{(tpdc_pkg::MUL_B_W-tpdc_pkg::FS_W){1'b0}}, fs_r});
      end
      default: ;
    endcase
  end

  // Output register: load on the last step, drop once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control and loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tpdc_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      ang_r       <= '0;
      integ_r     <= '0;
      sd_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ang_r       <= ang_nxt;
      integ_r     <= integ_nxt;
      sd_r        <= sd_nxt;
    end
  end

  // Working and result payload
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    gx_r   <= gx_nxt;
    tmp_r  <= tmp_nxt;
    err_r  <= err_nxt;
    acc_r  <= acc_nxt;
    diff_r <= diff_nxt;
    dcl_r  <= dcl_nxt;
    if (out_load) begin
      pwm_r     <= prod_r[tpdc_pkg::PWM_SH+tpdc_pkg::PWM_W-1:tpdc_pkg::PWM_SH];
      out_ang_r <= ang_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_pwm_level      = pwm_r;
  assign out_filtered_angle = out_ang_r;

`ifndef ASSERT_OFF
  // An accepted sample starts the CORDIC phase
  a_accept_to_cordic: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == tpdc_pkg::S_CORDIC))
    else $error("accepted sample did not start the CORDIC phase");

  // The CORDIC finishes only while the sequencer waits for it
  a_cordic_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    cor_done |-> (state_r == tpdc_pkg::S_CORDIC))
    else $error("CORDIC completion outside its phase");

  // A result appears only from the last step
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == tpdc_pkg::S_RESULT))
    else $error("result raised outside the result step");

  // Duty fed to the scaling multiply stays within 0..1
  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tpdc_pkg::S_MUL_PWM) |-> (dcl_r <= tpdc_pkg::DCL_W'(tpdc_pkg::DUTY_ONE)))
    else $error("clamped duty above one");
`endif

endmodule

// ===== bench/tpdc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt PID duty controller checker
// Watches the sample, result and register-write channels, keeps its own
// fixed-point copy of the filter and controller state, and compares every
// result transaction field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module tpdc_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic signed [tpdc_pkg::ACCEL_W-1:0] in_accel_y,
  input  logic signed [tpdc_pkg::ACCEL_W-1:0] in_accel_z,
  input  logic signed [tpdc_pkg::GYRO_W-1:0]  in_gyro_x,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic [tpdc_pkg::PWM_W-1:0]          out_pwm_level,
  input  logic signed [tpdc_pkg::ANGLE_W-1:0] out_filtered_angle,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [tpdc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tpdc_pkg::CFG_DATA_W-1:0]     cfg_data,
  output int                                  fail_count,
  output int                                  pending
);
  import tpdc_pkg::*;

  typedef struct packed {
    logic [PWM_W-1:0]   pwm_level;
    logic [ANGLE_W-1:0] filtered_angle;
  } tilt_result_t;

  // Arctangent of 2^-i, degrees in Q16
  localparam longint ATAN_Q16 [0:23] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  localparam longint HALF_TURN   = 11796480;        // 180 degrees, Q16
  localparam longint ANGLE_HI    = 16777215;
  localparam longint ANGLE_LO    = -16777216;
  localparam longint DUTY_HI     = (64'sd1 <<< 39) - 1;
  localparam longint DUTY_LO     = -(64'sd1 <<< 39);
  localparam longint DUTY_UNITY  = 64'sd1 <<< 24;
  localparam longint NEW_WEIGHT  = 65;              // 0.001 in Q16
  localparam longint KEEP_WEIGHT = 65470;           // 0.999 in Q16
  localparam int     REPORT_CAP  = 60;

  // Register copies
  logic [TARGET_W-1:0] target;
  logic [GAIN_W-1:0]   kp, ki, kd;
  logic [LIMIT_W-1:0]  limit;
  logic [FS_W-1:0]     full_scale;

  // Controller state
  longint angle_est, err_sum, duty_avg;

  tilt_result_t expected_q[$];
  int errors = 0;
  int depth  = 0;

  assign fail_count = errors;
  assign pending    = depth;

  function automatic longint bound(longint v, longint lo, longint hi);
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  // Vectoring CORDIC: angle of (ay, az) in Q16 degrees
  function automatic longint accel_tilt_deg(longint ay, longint az);
    longint px, pz, nx, nz, ang;
    px  = ay * 4096;
    pz  = az * 4096;
    ang = 0;
    if (ay == 0 && az == 0) begin
      return 0;
    end
    // left half plane: turn by a half revolution first
    if (px < 0) begin
      ang = (pz >= 0) ? HALF_TURN : -HALF_TURN;
      px  = -px;
      pz  = -pz;
    end
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      if (pz > 0) begin
        nx  = px + (pz >>> i);
        nz  = pz - (px >>> i);
        ang = ang + ATAN_Q16[i];
      end else begin
        nx  = px - (pz >>> i);
        nz  = pz + (px >>> i);
        ang = ang - ATAN_Q16[i];
      end
      px = nx;
      pz = nz;
    end
    return ang;
  endfunction

  // Advance filter, integrator and duty smoothing by one sample
  function automatic tilt_result_t advance_controller(longint ay, longint az, longint gx);
    tilt_result_t r;
    longint acc, delta, err, lim, raw, d;
    acc       = accel_tilt_deg(ay, az);
    delta     = (-gx * NEW_WEIGHT) >>> 16;
    angle_est = (((angle_est + delta) * KEEP_WEIGHT) >>> 16) + ((acc * NEW_WEIGHT) >>> 16);
    angle_est = bound(angle_est, ANGLE_LO, ANGLE_HI);

    err     = longint'(target) - angle_est;
    lim     = longint'(limit);
    err_sum = bound(err_sum + err, -lim, lim);

    raw      = longint'(kp) * err + longint'(ki) * err_sum + longint'(kd) * gx;
    raw      = bound(raw >>> 16, DUTY_LO, DUTY_HI);
    duty_avg = bound(duty_avg + ((raw - duty_avg) >>> 4), DUTY_LO, DUTY_HI);

    d = bound(duty_avg, 0, DUTY_UNITY);
    d = (d * longint'(full_scale)) >>> 24;
    r.pwm_level      = d[PWM_W-1:0];
    r.filtered_angle = angle_est[ANGLE_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin : watch
    tilt_result_t want;
    if (!rst_n) begin
      target     <= RST_TARGET;
      kp         <= RST_KP;
      ki         <= RST_KI;
      kd         <= RST_KD;
      limit      <= RST_LIMIT;
      full_scale <= RST_FS;
      angle_est  = 0;
      err_sum    = 0;
      duty_avg   = 0;
      expected_q.delete();
    end else begin
      // compare a result transaction with the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          errors++;
          if (errors < REPORT_CAP)
            $display("%0t: unexpected result, expected none, got pwm_level %0d angle %0d",
                     $time, out_pwm_level, out_filtered_angle);
        end else begin
          want = expected_q.pop_front();
          if (want.pwm_level !== out_pwm_level) begin
            errors++;
            if (errors < REPORT_CAP)
              $display("%0t: pwm_level expected %0d, got %0d",
                       $time, want.pwm_level, out_pwm_level);
          end
          if (want.filtered_angle !== out_filtered_angle) begin
            errors++;
            if (errors < REPORT_CAP)
              $display("%0t: filtered_angle expected %0d, got %0d",
                       $time, $signed(want.filtered_angle), out_filtered_angle);
          end
        end
      end

      // mirror register writes; spare indexes are dropped
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TARGET_ANGLE:    target     <= cfg_data[TARGET_W-1:0];
          CFG_GAIN_PROP:       kp         <= cfg_data[GAIN_W-1:0];
          CFG_GAIN_INTEG:      ki         <= cfg_data[GAIN_W-1:0];
          CFG_GAIN_DERIV:      kd         <= cfg_data[GAIN_W-1:0];
          CFG_INTEGRAL_LIMIT:  limit      <= cfg_data[LIMIT_W-1:0];
          CFG_DUTY_FULL_SCALE: full_scale <= cfg_data[FS_W-1:0];
          default: ;
        endcase
      end

      // predict the result of each accepted sample
      if (in_valid && !in_stall) begin
        expected_q.push_back(advance_controller(longint'(in_accel_y), longint'(in_accel_z),
                                                longint'(in_gyro_x)));
      end
    end
    depth <= expected_q.size();
  end

endmodule

// ===== bench/tilt_pid_duty_controller_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt PID duty controller testbench
// Drives IMU samples and register writes into the controller with random
// gaps and result back-pressure. A directed set of axis, quadrant and range
// corners comes first, then random samples under several register settings,
// then a run at full rate that drives the angle estimate hard towards its clamp.
// Checking is done by the checker instance beside the controller.
// ----------------------------------------------------------------------------
module tilt_pid_duty_controller_test;
  import tpdc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;
  localparam int DRAIN_CYCLES  = 48;
  localparam int PHASE_SAMPLES = 60;
  localparam int WINDUP_SAMPLES = 170;
  localparam int ACCEL_MIN = -262144;
  localparam int ACCEL_MAX = 262143;
  localparam int GYRO_MIN  = -16777216;
  localparam int GYRO_MAX  = 16777215;

  logic                      clk        = 1'b0;
  logic                      rst_n      = 1'b0;
  logic                      in_valid   = 1'b0;
  logic                      in_stall;
  logic signed [ACCEL_W-1:0] in_accel_y = '0;
  logic signed [ACCEL_W-1:0] in_accel_z = '0;
  logic signed [GYRO_W-1:0]  in_gyro_x  = '0;
  logic                      out_valid;
  logic                      out_stall  = 1'b0;
  logic [PWM_W-1:0]          out_pwm_level;
  logic signed [ANGLE_W-1:0] out_filtered_angle;
  logic                      cfg_valid  = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index  = '0;
  logic [CFG_DATA_W-1:0]     cfg_data   = '0;

  bit quiet   = 1'b0;   // no idling on either side
  bit gaps_on = 1'b1;
  int fail_count;
  int pending;

  tilt_pid_duty_controller dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_accel_y         (in_accel_y),
    .in_accel_z         (in_accel_z),
    .in_gyro_x          (in_gyro_x),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_pwm_level      (out_pwm_level),
    .out_filtered_angle (out_filtered_angle),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  tpdc_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_accel_y         (in_accel_y),
    .in_accel_z         (in_accel_z),
    .in_gyro_x          (in_gyro_x),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_pwm_level      (out_pwm_level),
    .out_filtered_angle (out_filtered_angle),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .fail_count         (fail_count),
    .pending            (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Give up on a hung run
  initial begin
    #5000000;
    $display("status: fail");
    $finish;
  end

  // Result back-pressure: stall bursts between free-running stretches
  initial begin : result_backpressure
    int  span;
    bit  hold;
    forever begin
      hold = !quiet && !hold && ($urandom_range(0, 2) == 0);
      span = hold ? $urandom_range(1, 12) : $urandom_range(1, 40);
      repeat (span) begin
        @(posedge clk);
        out_stall <= hold && !quiet;
      end
    end
  end

  // Present one sample, with an optional gap, and hold it until taken
  task automatic send_sample(input int ay, input int az, input int gx);
    if (!quiet && gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_accel_y <= ay[ACCEL_W-1:0];
    in_accel_z <= az[ACCEL_W-1:0];
    in_gyro_x  <= gx[GYRO_W-1:0];
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Write every register, then a spare index that must change nothing
  task automatic load_settings(input int unsigned target, kp, ki, kd, limit, fs);
    write_reg(CFG_TARGET_ANGLE, target[CFG_DATA_W-1:0]);
    write_reg(CFG_GAIN_PROP, kp[CFG_DATA_W-1:0]);
    write_reg(CFG_GAIN_INTEG, ki[CFG_DATA_W-1:0]);
    write_reg(CFG_GAIN_DERIV, kd[CFG_DATA_W-1:0]);
    write_reg(CFG_INTEGRAL_LIMIT, limit[CFG_DATA_W-1:0]);
    write_reg(CFG_DUTY_FULL_SCALE, fs[CFG_DATA_W-1:0]);
    write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait for every outstanding result, then let the sequencer settle
  task automatic drain;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic int corner(input int lo, input int hi);
    case ($urandom_range(0, 4))
      0:       return lo;
      1:       return -1;
      2:       return 0;
      3:       return 1;
      default: return hi;
    endcase
  endfunction

  // Mostly plausible tilts, some full-range noise, some range corners
  task automatic random_sample(output int ay, output int az, output int gx);
    int kind;
    kind = $urandom_range(0, 3);
    case (kind)
      0, 1: begin
        ay = int'($urandom_range(0, 98304)) - 16384;
        az = int'($urandom_range(0, 131072)) - 65536;
        gx = int'($urandom_range(0, 13107200)) - 6553600;
      end
      2: begin
        ay = int'($urandom);
        az = int'($urandom);
        gx = int'($urandom);
      end
      default: begin
        ay = corner(ACCEL_MIN, ACCEL_MAX);
        az = corner(ACCEL_MIN, ACCEL_MAX);
        gx = corner(GYRO_MIN, GYRO_MAX);
      end
    endcase
  endtask

  initial begin : stimulus
    int ay, az, gx;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corners at reset settings
    send_sample(0, 0, 0);                       // zero vector
    send_sample(-1000, 0, 0);                   // negative y, z on the axis
    send_sample(-1000, -1, 0);                  // negative y, z below
    send_sample(-1, 0, 0);
    send_sample(ACCEL_MAX, 0, 0);
    send_sample(ACCEL_MIN, 0, 0);
    send_sample(0, ACCEL_MAX, 0);
    send_sample(0, ACCEL_MIN, 0);
    send_sample(ACCEL_MAX, ACCEL_MAX, GYRO_MAX);
    send_sample(ACCEL_MIN, ACCEL_MIN, GYRO_MIN);
    send_sample(ACCEL_MIN, ACCEL_MAX, GYRO_MAX);
    send_sample(ACCEL_MAX, ACCEL_MIN, GYRO_MIN);
    send_sample(1, -1, -1);
    send_sample(1, 1, 1);
    send_sample(65536, 11585, 655360);
    send_sample(-65536, -65536, -655360);
    send_sample(0, 1, 0);
    send_sample(0, -1, 0);
    in_valid <= 1'b0;
    drain;

    // Random samples under a range of register settings
    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       load_settings(131072, 0, 0, 0, 0, 0);
        1:       load_settings(9830400, 32'hFFFFFF, 32'hFFFFFF, 32'hFFFFFF, 1179648000, 65535);
        2:       load_settings(32'hFFFFFF, $urandom, $urandom, $urandom, 32'h7FFFFFFF, 1);
        3:       load_settings(32'(RST_TARGET), 32'(RST_KP), 32'(RST_KI) * 64, 32'(RST_KD),
                               $urandom_range(0, 4000000), 32'(RST_FS));
        default: load_settings($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      endcase
      for (int n = 0; n < PHASE_SAMPLES; n++) begin
        if (n % 30 == 0) gaps_on = ($urandom_range(0, 3) != 0);
        random_sample(ay, az, gx);
        send_sample(ay, az, gx);
      end
      in_valid <= 1'b0;
      drain;
    end

    // Full rate: near-opposite gravity and extreme rate push the angle towards its clamp
    load_settings(32'(RST_TARGET), $urandom_range(0, 1000000), $urandom_range(0, 20000),
                  $urandom_range(0, 400000), $urandom_range(0, 50000000), 32'hFFFF);
    quiet = 1'b1;
    for (int n = 0; n < WINDUP_SAMPLES; n++) begin
      send_sample(ACCEL_MIN + int'($urandom_range(0, 4095)), int'($urandom_range(0, 4095)),
                  GYRO_MIN + int'($urandom_range(0, 4095)));
    end
    in_valid <= 1'b0;
    drain;

    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/tpdc_pkg.sv
hw/rtl/tpdc_cordic.sv
hw/rtl/tilt_pid_duty_controller.sv
bench/tpdc_checker.sv
bench/tilt_pid_duty_controller_test.sv
